// ===== hdl/lsgpf_pkg.sv =====
// Package for the laser scan ground point filter.
// Holds widths, register indexes, limits, FSM states, commands and the sine step functions.
package lsgpf_pkg;

  localparam int MaxSamples = 4096;
  localparam int IdxW       = $clog2(MaxSamples);
  localparam int CntW       = 13;
  localparam int RegIdxW    = 3;
  localparam int CfgDataW   = 18;

  localparam logic [RegIdxW-1:0] RegQuatW   = 3'd0;
  localparam logic [RegIdxW-1:0] RegQuatX   = 3'd1;
  localparam logic [RegIdxW-1:0] RegQuatY   = 3'd2;
  localparam logic [RegIdxW-1:0] RegQuatZ   = 3'd3;
  localparam logic [RegIdxW-1:0] RegHeight  = 3'd4;
  localparam logic [RegIdxW-1:0] RegReplace = 3'd5;
  localparam logic [RegIdxW-1:0] RegStart   = 3'd6;
  localparam logic [RegIdxW-1:0] RegStep    = 3'd7;

  localparam logic signed [17:0] HeightMax   = 18'sd131071;
  localparam logic signed [17:0] HeightMin   = -18'sd131072;
  localparam logic signed [17:0] GroundLimit = 18'sd100;
  localparam logic [CntW-1:0]    CountMax    = 13'd8191;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANGLE, ST_FOLD, ST_POLY, ST_TRIG, ST_XMUL, ST_YMUL, ST_AMUL1, ST_AMUL2,
    ST_BMUL1, ST_BMUL2, ST_ZA, ST_ZB, ST_FINISH, ST_OUT
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic angle;
    logic fold;
    logic poly;
    logic trig;
    logic xmul;
    logic ymul;
    logic amul1;
    logic amul2;
    logic bmul1;
    logic bmul2;
    logic za;
    logic zb;
    logic finish;
  } cmd_t;

  // Folds a binary angle onto a quarter turn, 16384 being a quarter turn.
  function automatic logic [14:0] sin_fold(input logic [15:0] ang);
    sin_fold = (ang[14:0] > 15'd16384) ? 15'(16'd32768 - {1'b0, ang[14:0]}) : ang[14:0];
  endfunction

  // Square of the folded angle, scaled back by 2^14.
  function automatic logic [14:0] sin_square(input logic [14:0] z);
    logic [29:0] p;
    p = {15'd0, z} * {15'd0, z};
    sin_square = p[28:14];
  endfunction

  // Inner polynomial term from the scaled square.
  function automatic logic [13:0] sin_poly(input logic [14:0] z2);
    logic [25:0] p1;
    logic [11:0] t1;
    logic [28:0] p2;
    p1 = {11'd0, z2} * 26'd1160;
    t1 = p1[25:14];
    p2 = {14'd0, z2} * 29'(14'd10512 - {2'd0, t1});
    sin_poly = p2[27:14];
  endfunction

  // Q1.14 sine magnitude from the folded angle and the inner term.
  function automatic logic [15:0] sin_mag(input logic [14:0] z, input logic [13:0] t2);
    logic [30:0] p;
    p = {16'd0, z} * 31'(15'd25736 - {1'b0, t2});
    sin_mag = p[29:14];
  endfunction

endpackage

// ===== hdl/lsgpf_if.sv =====
// Valid/ready channel interfaces for the ground point filter.
// Depends on lsgpf_pkg for widths.
interface lsgpf_in_if import lsgpf_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        sample_valid;
  logic        last_in_scan;
  modport source (output valid, range_mm, sample_valid, last_in_scan, input ready);
  modport sink   (input valid, range_mm, sample_valid, last_in_scan, output ready);
endinterface

interface lsgpf_out_if import lsgpf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [15:0]            filtered_range;
  logic                   is_ground;
  logic signed [17:0]     world_height;
  logic [CntW-1:0]        removed_so_far;
  logic                   last_out;
  modport source (output valid, filtered_range, is_ground, world_height, removed_so_far,
                  last_out, input ready);
  modport sink   (input valid, filtered_range, is_ground, world_height, removed_so_far,
                  last_out, output ready);
endinterface

interface lsgpf_cfg_if import lsgpf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RegIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/laser_scan_ground_point_filter.sv =====
// Top level of the laser scan ground point filter.
// Depends on lsgpf_pkg, the channel interfaces, lsgpf_ctrl and lsgpf_dp.

// A valid sample's result word is offered once the sequencer has run the steps
// below, and an invalid sample skips them and goes straight to the ground test
// step; the word then waits until it is taken, and the next sample is accepted
// in the cycle after that. The sequencer takes one step for the beam angle,
// three for the cosine and sine polynomials, six for the products of the range
// projection and the quaternion terms on one shared 18x18 multiplier, two
// accumulating steps for the rotated height and one for the ground test. One
// sample is in work at a time. The sample index and removal count clear after
// the word marked last is taken.
module laser_scan_ground_point_filter import lsgpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsgpf_in_if.sink    in_if,
  lsgpf_out_if.source out_if,
  lsgpf_cfg_if.sink   cfg_if
);

  cmd_t cmd;
  logic out_valid;

  // Configuration is always taken.
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid;

  lsgpf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_if.valid),
    .sample_valid_i (in_if.sample_valid),
    .out_ready_i    (out_if.ready),
    .in_ready_o     (in_if.ready),
    .out_valid_o    (out_valid),
    .cmd_o          (cmd)
  );

  lsgpf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .out_done_i       (out_valid && out_if.ready),
    .range_mm_i       (in_if.range_mm),
    .sample_valid_i   (in_if.sample_valid),
    .last_in_scan_i   (in_if.last_in_scan),
    .cfg_we_i         (cfg_if.valid),
    .cfg_index_i      (cfg_if.index),
    .cfg_data_i       (cfg_if.data),
    .filtered_range_o (out_if.filtered_range),
    .is_ground_o      (out_if.is_ground),
    .world_height_o   (out_if.world_height),
    .removed_so_far_o (out_if.removed_so_far),
    .last_out_o       (out_if.last_out)
  );

endmodule

// ===== hdl/lsgpf_ctrl.sv =====
// Controller state machine of the ground point filter.
// Depends on lsgpf_pkg for state and command types.
module lsgpf_ctrl import lsgpf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   sample_valid_i,
  input  logic   out_ready_i,
  output logic   in_ready_o,
  output logic   out_valid_o,
  output cmd_t   cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Next state. Invalid samples skip the arithmetic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = sample_valid_i ? ST_ANGLE : ST_FINISH;
      ST_ANGLE:  state_d = ST_FOLD;
      ST_FOLD:   state_d = ST_POLY;
      ST_POLY:   state_d = ST_TRIG;
      ST_TRIG:   state_d = ST_XMUL;
      ST_XMUL:   state_d = ST_YMUL;
      ST_YMUL:   state_d = ST_AMUL1;
      ST_AMUL1:  state_d = ST_AMUL2;
      ST_AMUL2:  state_d = ST_BMUL1;
      ST_BMUL1:  state_d = ST_BMUL2;
      ST_BMUL2:  state_d = ST_ZA;
      ST_ZA:     state_d = ST_ZB;
      ST_ZB:     state_d = ST_FINISH;
      ST_FINISH: state_d = ST_OUT;
      ST_OUT:    if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_ANGLE:  cmd_o.angle  = 1'b1;
      ST_FOLD:   cmd_o.fold   = 1'b1;
      ST_POLY:   cmd_o.poly   = 1'b1;
      ST_TRIG:   cmd_o.trig   = 1'b1;
      ST_XMUL:   cmd_o.xmul   = 1'b1;
      ST_YMUL:   cmd_o.ymul   = 1'b1;
      ST_AMUL1:  cmd_o.amul1  = 1'b1;
      ST_AMUL2:  cmd_o.amul2  = 1'b1;
      ST_BMUL1:  cmd_o.bmul1  = 1'b1;
      ST_BMUL2:  cmd_o.bmul2  = 1'b1;
      ST_ZA:     cmd_o.za     = 1'b1;
      ST_ZB:     cmd_o.zb     = 1'b1;
      ST_FINISH: cmd_o.finish = 1'b1;
      ST_OUT:    out_valid_o  = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

endmodule

// ===== hdl/lsgpf_dp.sv =====
// Datapath of the ground point filter: angle, sine, rotation, test, counters.
// Depends on lsgpf_pkg for widths, constants, commands and the sine step functions.
module lsgpf_dp import lsgpf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  input  logic                   out_done_i,
  input  logic [15:0]            range_mm_i,
  input  logic                   sample_valid_i,
  input  logic                   last_in_scan_i,
  input  logic                   cfg_we_i,
  input  logic [RegIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  output logic [15:0]            filtered_range_o,
  output logic                   is_ground_o,
  output logic signed [17:0]     world_height_o,
  output logic [CntW-1:0]        removed_so_far_o,
  output logic                   last_out_o
);

  logic signed [15:0] qw_q, qx_q, qy_q, qz_q, start_q;
  logic signed [17:0] height_cfg_q;
  logic [15:0]        repl_q;
  logic [12:0]        step_q;
  logic [IdxW-1:0]    idx_q;
  logic [CntW-1:0]    cnt_q;

  logic [15:0]        range_q, ang_q;
  logic               valid_q, last_q;
  logic [14:0]        cz_q, sz_q, cz2_q, sz2_q;
  logic [13:0]        ct2_q, st2_q;
  logic               cneg_q, sneg_q;
  logic signed [15:0] cos_q, sin_q;
  logic signed [17:0] x_q, y_q;
  logic signed [31:0] p_q;
  logic signed [33:0] a_q, b_q;
  logic signed [53:0] acc_q;
  logic [15:0]        filt_q;
  logic               gnd_q;
  logic signed [17:0] wh_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qw_q <= 16'sd16384; qx_q <= '0; qy_q <= '0; qz_q <= '0;
      height_cfg_q <= '0; repl_q <= 16'hFFFF; start_q <= -16'sd16384; step_q <= 13'd64;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegQuatW:   qw_q <= cfg_data_i[15:0];
        RegQuatX:   qx_q <= cfg_data_i[15:0];
        RegQuatY:   qy_q <= cfg_data_i[15:0];
        RegQuatZ:   qz_q <= cfg_data_i[15:0];
        RegHeight:  height_cfg_q <= cfg_data_i;
        RegReplace: repl_q <= cfg_data_i[15:0];
        RegStart:   start_q <= cfg_data_i[15:0];
        RegStep:    step_q <= cfg_data_i[12:0];
        default:    ;
      endcase
    end
  end

  // Cosine angle is a quarter turn ahead; magnitudes of the last sine step.
  logic [15:0] cang;
  logic [15:0] cmag;
  logic [15:0] smag;
  assign cang = 16'(ang_q + 16'd16384);
  assign cmag = sin_mag(cz_q, ct2_q);
  assign smag = sin_mag(sz_q, st2_q);

  // Shared multiplier operands.
  logic signed [17:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [35:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.xmul)       begin mul_a = $signed({2'b00, range_q}); mul_b = 18'(cos_q); end
    else if (cmd_i.ymul)  begin mul_a = $signed({2'b00, range_q}); mul_b = 18'(sin_q); end
    else if (cmd_i.amul1) begin mul_a = 18'(qx_q); mul_b = 18'(qz_q); end
    else if (cmd_i.amul2) begin mul_a = 18'(qw_q); mul_b = 18'(qy_q); end
    else if (cmd_i.bmul1) begin mul_a = 18'(qy_q); mul_b = 18'(qz_q); end
    else if (cmd_i.bmul2) begin mul_a = 18'(qw_q); mul_b = 18'(qx_q); end
  end
  assign mul_p = mul_a * mul_b;

  // Round half up by 2^14 of the range product.
  logic signed [35:0] rnd_xy;
  assign rnd_xy = (mul_p + 36'sd8192) >>> 14;

  // Second product of the rotation: a or b (34 bit) times x or y (18 bit).
  logic signed [53:0] zprod;
  assign zprod = cmd_i.za ? (54'(a_q) * 54'(x_q)) : (54'(b_q) * 54'(y_q));

  // Final height: round by 2^28, add offset, saturate.
  logic signed [53:0] zr;
  logic signed [53:0] hsum;
  logic signed [17:0] hsat;
  assign zr   = (acc_q + 54'sd134217728) >>> 28;
  assign hsum = zr + 54'(height_cfg_q);
  always_comb begin
    if (hsum > 54'(HeightMax))      hsat = HeightMax;
    else if (hsum < 54'(HeightMin)) hsat = HeightMin;
    else                            hsat = hsum[17:0];
  end
  logic ground;
  assign ground = valid_q && (hsat < GroundLimit);

  // Work registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      range_q <= range_mm_i;
      valid_q <= sample_valid_i;
      last_q  <= last_in_scan_i;
      acc_q   <= '0;
    end
    if (cmd_i.angle)  ang_q <= 16'(start_q) + 16'({4'd0, idx_q} * {16'd0, step_q});
    // Sine and cosine in three steps: fold and square, inner term, magnitude and sign.
    if (cmd_i.fold) begin
      cz_q   <= sin_fold(cang);
      sz_q   <= sin_fold(ang_q);
      cz2_q  <= sin_square(sin_fold(cang));
      sz2_q  <= sin_square(sin_fold(ang_q));
      cneg_q <= cang[15];
      sneg_q <= ang_q[15];
    end
    if (cmd_i.poly) begin
      ct2_q <= sin_poly(cz2_q);
      st2_q <= sin_poly(sz2_q);
    end
    if (cmd_i.trig) begin
      cos_q <= cneg_q ? -$signed(cmag) : $signed(cmag);
      sin_q <= sneg_q ? -$signed(smag) : $signed(smag);
    end
    if (cmd_i.xmul)   x_q <= rnd_xy[17:0];
    if (cmd_i.ymul)   y_q <= rnd_xy[17:0];
    if (cmd_i.amul1 || cmd_i.bmul1) p_q <= mul_p[31:0];
    if (cmd_i.amul2)  a_q <= (34'(p_q) - 34'($signed(mul_p[31:0]))) <<< 1;
    if (cmd_i.bmul2)  b_q <= (34'(p_q) + 34'($signed(mul_p[31:0]))) <<< 1;
    if (cmd_i.za || cmd_i.zb) acc_q <= acc_q + zprod;
    if (cmd_i.finish) begin
      filt_q <= ground ? repl_q : range_q;
      gnd_q  <= ground;
      wh_q   <= valid_q ? hsat : '0;
    end
  end

  // Removal count rises at the ground test; index steps once the word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.finish) begin
      if (ground && cnt_q != CountMax) cnt_q <= cnt_q + 1'b1;
    end else if (out_done_i) begin
      if (last_q) begin
        idx_q <= '0;
        cnt_q <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign filtered_range_o = filt_q;
  assign is_ground_o      = gnd_q;
  assign world_height_o   = wh_q;
  assign removed_so_far_o = cnt_q;
  assign last_out_o       = last_q;

endmodule

// ===== verif/tb.sv =====
// Testbench for the laser scan ground point filter: drives range samples and
// register writes, predicts each result word and compares it field by field.
// Depends on lsgpf_pkg, the channel interfaces in hdl/lsgpf_if.sv and the RTL.
`timescale 1ns / 1ps

// One result word as the checker sees it.
typedef struct packed {
  logic [15:0]        rng;
  logic               gnd;
  logic signed [17:0] hgt;
  logic [12:0]        cnt;
  logic               lst;
} word_t;

// Holds the predicted result words in acceptance order and checks arrivals.
class ground_scoreboard;
  word_t pending_q[$];
  int    errors;

  function void note_sample(word_t w);
    pending_q = {pending_q, w};
  endfunction

  function void report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endfunction

  function void check_word(word_t got);
    word_t w;
    if (pending_q.size() == 0) begin
      report("result word with nothing expected");
      return;
    end
    w = pending_q.pop_front();
    if (got.rng !== w.rng) report($sformatf("range got %0d want %0d", got.rng, w.rng));
    if (got.gnd !== w.gnd) report($sformatf("ground got %0b want %0b", got.gnd, w.gnd));
    if (got.hgt !== w.hgt) report($sformatf("height got %0d want %0d", got.hgt, w.hgt));
    if (got.cnt !== w.cnt) report($sformatf("count got %0d want %0d", got.cnt, w.cnt));
    if (got.lst !== w.lst) report($sformatf("last got %0b want %0b", got.lst, w.lst));
  endfunction
endclass

module tb import lsgpf_pkg::*; ();

  localparam int CycleLimit = 2000000;

  logic clk_i;
  logic rst_ni;
  lsgpf_in_if  in_if ();
  lsgpf_out_if out_if ();
  lsgpf_cfg_if cfg_if ();

  laser_scan_ground_point_filter u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  ground_scoreboard sb;

  // Shadow copy of the registers and scan state.
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [17:0] sens_h;
  logic [15:0]        repl_rng;
  logic signed [15:0] ang0;
  logic [12:0]        ang_step;
  logic [IdxW-1:0]    scan_idx;
  logic [12:0]        removed_cnt;

  int send_idle_pct;
  int recv_stall_pct;
  longint cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, each taken word checked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready)
        sb.check_word({out_if.filtered_range, out_if.is_ground, out_if.world_height,
                       out_if.removed_so_far, out_if.last_out});
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic signed [17:0] sine_q14(logic [15:0] a);
    logic [31:0] z, z2, s;
    z = {17'd0, a[14:0]};
    if (z > 16384) z = 32768 - z;
    z2 = (z * z) >> 14;
    s = (z * (25736 - ((z2 * (10512 - ((z2 * 1160) >> 14))) >> 14))) >> 14;
    return a[15] ? -$signed({2'b0, s[15:0]}) : $signed({2'b0, s[15:0]});
  endfunction

  // Floor of (v + half) / 2^sh, half rounding toward plus infinity.
  function automatic longint round_sh(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Predicts the result of one sample and advances the scan state.
  function automatic word_t predict_sample(logic [15:0] r, logic v, logic l);
    word_t w;
    logic [15:0] ang;
    longint c, s, x, y, a, b, h;
    w = '0;
    w.rng = r;
    h = 0;
    if (v) begin
      ang = 16'(ang0 + scan_idx * ang_step);
      c = sine_q14(16'(ang + 16'd16384));
      s = sine_q14(ang);
      x = round_sh(longint'(r) * c, 14);
      y = round_sh(longint'(r) * s, 14);
      a = 2 * (longint'(qx) * qz - longint'(qw) * qy);
      b = 2 * (longint'(qy) * qz + longint'(qw) * qx);
      h = round_sh(a * x + b * y, 28) + sens_h;
      if (h > 131071) h = 131071;
      if (h < -131072) h = -131072;
      if (h < 100) begin
        w.rng = repl_rng;
        w.gnd = 1'b1;
        if (removed_cnt != CountMax) removed_cnt++;
      end
    end
    w.hgt = 18'(h);
    w.cnt = removed_cnt;
    w.lst = l;
    if (l) begin
      scan_idx = '0;
      removed_cnt = '0;
    end else begin
      scan_idx = scan_idx + 1'b1;
    end
    return w;
  endfunction

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegQuatW:   qw = d[15:0];
      RegQuatX:   qx = d[15:0];
      RegQuatY:   qy = d[15:0];
      RegQuatZ:   qz = d[15:0];
      RegHeight:  sens_h = d;
      RegReplace: repl_rng = d[15:0];
      RegStart:   ang0 = d[15:0];
      RegStep:    ang_step = d[12:0];
      default: ;
    endcase
  endtask

  // Sends one sample; valid stays high across back-to-back samples.
  task automatic send_sample(logic [15:0] r, logic v, logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.range_mm     <= r;
    in_if.sample_valid <= v;
    in_if.last_in_scan <= l;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_sample(predict_sample(r, v, l));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_samples(int n);
    logic [15:0] r;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: r = 16'($urandom);
        1: r = 16'($urandom_range(2000));
        2: r = 16'($urandom_range(20000));
        default: r = ($urandom_range(1)) ? 16'hFFFF : 16'd0;
      endcase
      send_sample(r, $urandom_range(9) != 0, $urandom_range(19) == 0);
    end
  endtask

  // One random attitude and geometry setting, extremes now and then.
  task automatic random_setting();
    logic [CfgDataW-1:0] d;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(3))
        0: d = 18'(16384);
        1: d = 18'(-16384);
        default: d = 18'($signed($urandom_range(32768)) - 16384);
      endcase
      write_reg(RegIdxW'(i), d);
    end
    write_reg(RegHeight, $urandom_range(3) == 0 ? 18'h1FFFF : 18'($urandom_range(3000)));
    write_reg(RegReplace, 18'($urandom));
    write_reg(RegStart, 18'($urandom));
    write_reg(RegStep, $urandom_range(1) ? 18'($urandom_range(4096, 1)) : 18'($urandom));
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    qw = 16384; qx = 0; qy = 0; qz = 0;
    sens_h = 0; repl_rng = 16'hFFFF; ang0 = -16384; ang_step = 64;
    scan_idx = '0; removed_cnt = '0;
    in_if.valid = 1'b0; in_if.range_mm = '0;
    in_if.sample_valid = 1'b0; in_if.last_in_scan = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, field extremes, invalid samples, last marker.
    send_sample(16'd0, 1'b1, 1'b0);
    send_sample(16'hFFFF, 1'b1, 1'b0);
    send_sample(16'hFFFF, 1'b0, 1'b0);
    send_sample(16'd0, 1'b0, 1'b1);
    drain();
    // Pitched sensor, high and low ground; extreme heights saturate.
    write_reg(RegQuatW, 18'(11585));
    write_reg(RegQuatY, 18'(11585));
    write_reg(RegHeight, 18'h1FFFF);
    write_reg(RegStep, 18'd4096);
    for (int i = 0; i < 6; i++) send_sample(16'hFFFF, 1'b1, i == 5);
    drain();
    write_reg(RegHeight, 18'h20000);
    write_reg(RegReplace, 18'd0);
    write_reg(RegStart, 18'h08000);
    write_reg(RegStep, 18'h1FFF);
    for (int i = 0; i < 6; i++) send_sample(16'(i * 13000), i != 3, i == 5);
    drain();
    write_reg(RegQuatX, 18'(-16384));
    write_reg(RegQuatZ, 18'(16384));
    write_reg(RegStep, 18'd0);
    for (int i = 0; i < 5; i++) send_sample(16'($urandom), 1'b1, i == 4);
    drain();

    // Random phases with varying idle patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      random_setting();
      random_samples(75);
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/lsgpf_pkg.sv
hdl/lsgpf_if.sv
hdl/lsgpf_ctrl.sv
hdl/lsgpf_dp.sv
hdl/laser_scan_ground_point_filter.sv
verif/tb.sv
